// File: hw/rtl/dsc_pkg.sv
// dsc_pkg: shared widths, register indexes and constants for the
// distance speed controller; no dependencies
package dsc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int THRESH_BITS = 16;
    localparam int CMP_BITS    = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int SPEED_BITS  = 8;
    localparam int MAG_BITS    = 7;
    localparam int COUNT_BITS  = 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVERRIDE_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVERRIDE_LEFT   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVERRIDE_RIGHT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR_THRESHOLD  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAR_THRESHOLD   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEARCH_DURATION = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEARCH_SPEED    = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SPEED       = 3'd7;

    // register reset values
    localparam int NEAR_RESET     = 20;
    localparam int FAR_RESET      = 40;
    localparam int DURATION_RESET = 110;
    localparam int SEARCH_RESET   = 40;
    localparam int MIN_RESET      = 6;

    // ramp law: (RAMP_BASE - |change|) * (d - RAMP_BASE) / 4
    localparam int RAMP_BASE  = 20;
    localparam int FULL_SPEED = 100;

    typedef logic [SAMPLE_BITS-1:0]       sample_t;
    typedef logic signed [SPEED_BITS-1:0] speed_t;

endpackage

// File: hw/rtl/dsc_channels.sv
// dsc_channels: valid/ready channel interfaces for sample requests and
// speed results; depends on dsc_pkg
interface dsc_sample_if
    import dsc_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t distance_sample;

    modport source (output valid, output distance_sample, input ready);
    modport sink   (input valid, input distance_sample, output ready);
endinterface

interface dsc_speed_if
    import dsc_pkg::*;
();
    logic   valid;
    logic   ready;
    speed_t left_speed;
    speed_t right_speed;
    logic   searching;

    modport source (output valid, output left_speed, output right_speed,
                    output searching, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input searching, output ready);
endinterface

// File: hw/rtl/distance_speed_controller_top.sv
// distance_speed_controller_top: distance driven wheel speed controller
// depends on dsc_pkg and the channel interfaces in dsc_channels
//
//   channel    | dir | payload                                | handshake
//   -----------+-----+----------------------------------------+-------------
//   sample_ch  | in  | distance_sample (16 b unsigned)        | valid/ready
//   speed_ch   | out | left_speed, right_speed (8 b signed),  | valid/ready
//              |     | searching (1 b)                        |
//   cfg        | in  | cfg_we, cfg_index (3 b), cfg_data (16 b)| write only
//
// one request per cycle sustained while speed_ch is not stalled; a result is
// offered once its request has passed the input register, then the result register
// the decision, ramp multiply and state update sit between those two registers
// a stalled result holds in the result register while the input register
// still takes one more request
// rst_n clears the controller state and loads the register defaults
module distance_speed_controller_top
    import dsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    dsc_sample_if.sink                sample_ch,
    dsc_speed_if.source               speed_ch,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int PROD_BITS = 2 * (SAMPLE_BITS + 2);

    // configuration registers
    logic                   ovr_en_reg;
    speed_t                 ovr_left_reg;
    speed_t                 ovr_right_reg;
    logic [THRESH_BITS-1:0] near_reg;
    logic [THRESH_BITS-1:0] far_reg;
    logic [COUNT_BITS-1:0]  duration_reg;
    logic [MAG_BITS-1:0]    search_spd_reg;
    logic [MAG_BITS-1:0]    min_spd_reg;

    // controller state
    sample_t               prev_reg;
    logic                  seen_first_reg;
    logic                  active_reg;
    logic                  phase_reg;
    logic [COUNT_BITS-1:0] count_reg;
    speed_t                held_left_reg;
    speed_t                held_right_reg;

    logic                  active_next;
    logic                  phase_next;
    logic [COUNT_BITS-1:0] count_next;
    speed_t                left_next;
    speed_t                right_next;

    // pipeline registers
    logic    s1_valid_reg;
    sample_t s1_sample_reg;
    logic    out_valid_reg;
    speed_t  out_left_reg;
    speed_t  out_right_reg;
    logic    out_search_reg;

    logic s1_adv;
    logic in_take;

    // datapath
    logic signed [SAMPLE_BITS:0]   change;
    logic signed [SAMPLE_BITS:0]   change_abs;
    sample_t                       mag;
    logic signed [SAMPLE_BITS+1:0] ramp_a;
    logic signed [SAMPLE_BITS+1:0] ramp_b;
    logic signed [PROD_BITS-1:0]   prod;
    logic [PROD_BITS-3:0]          quarter;
    logic [MAG_BITS-1:0]           ramp_spd;
    logic [COUNT_BITS:0]           cnt_inc;
    logic [CMP_BITS-1:0]           d_cmp;

    // handshake: result register frees when empty or taken
    assign s1_adv  = s1_valid_reg && (!out_valid_reg || speed_ch.ready);
    assign in_take = sample_ch.valid && sample_ch.ready;

    assign sample_ch.ready      = !s1_valid_reg || s1_adv;
    assign speed_ch.valid       = out_valid_reg;
    assign speed_ch.left_speed  = out_left_reg;
    assign speed_ch.right_speed = out_right_reg;
    assign speed_ch.searching   = out_search_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovr_en_reg     <= 1'b0;
            ovr_left_reg   <= '0;
            ovr_right_reg  <= '0;
            near_reg       <= THRESH_BITS'(NEAR_RESET);
            far_reg        <= THRESH_BITS'(FAR_RESET);
            duration_reg   <= COUNT_BITS'(DURATION_RESET);
            search_spd_reg <= MAG_BITS'(SEARCH_RESET);
            min_spd_reg    <= MAG_BITS'(MIN_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OVERRIDE_ENABLE: ovr_en_reg     <= cfg_data[0];
                REG_OVERRIDE_LEFT:   ovr_left_reg   <= cfg_data[SPEED_BITS-1:0];
                REG_OVERRIDE_RIGHT:  ovr_right_reg  <= cfg_data[SPEED_BITS-1:0];
                REG_NEAR_THRESHOLD:  near_reg       <= cfg_data[THRESH_BITS-1:0];
                REG_FAR_THRESHOLD:   far_reg        <= cfg_data[THRESH_BITS-1:0];
                REG_SEARCH_DURATION: duration_reg   <= cfg_data[COUNT_BITS-1:0];
                REG_SEARCH_SPEED:    search_spd_reg <= cfg_data[MAG_BITS-1:0];
                REG_MIN_SPEED:       min_spd_reg    <= cfg_data[MAG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // magnitude of the change against the previous sample, zero on the first tick
    always_comb
    begin
        change     = $signed({1'b0, s1_sample_reg}) - $signed({1'b0, prev_reg});
        change_abs = change[SAMPLE_BITS] ? -change : change;
        mag        = seen_first_reg ? change_abs[SAMPLE_BITS-1:0] : '0;
    end

    // ramp: signed product, negative gives zero, quarter saturates at full speed
    always_comb
    begin
        ramp_a  = (SAMPLE_BITS+2)'(RAMP_BASE) - {2'b00, mag};
        ramp_b  = {2'b00, s1_sample_reg} - (SAMPLE_BITS+2)'(RAMP_BASE);
        prod    = ramp_a * ramp_b;
        quarter = prod[PROD_BITS-1:2];
        if (prod[PROD_BITS-1])
            ramp_spd = '0;
        else if (quarter > (PROD_BITS-2)'(FULL_SPEED))
            ramp_spd = MAG_BITS'(FULL_SPEED);
        else
            ramp_spd = quarter[MAG_BITS-1:0];
    end

    // tick decision
    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        left_next   = held_left_reg;
        right_next  = held_right_reg;
        cnt_inc     = {1'b0, count_reg} + (COUNT_BITS+1)'(1);
        d_cmp       = CMP_BITS'(s1_sample_reg);

        if (ovr_en_reg)
        begin
            left_next  = ovr_left_reg;
            right_next = ovr_right_reg;
        end
        else if (active_reg)
        begin
            if (!phase_reg)
            begin
                // spin in place, count ticks
                left_next  = SPEED_BITS'(0) - {1'b0, search_spd_reg};
                right_next = {1'b0, search_spd_reg};
                if (cnt_inc > {1'b0, duration_reg})
                    phase_next = 1'b1;
                count_next = cnt_inc[COUNT_BITS] ? '1 : cnt_inc[COUNT_BITS-1:0];
            end
            else
            begin
                // hold last speeds for one tick, then leave search
                active_next = 1'b0;
            end
        end
        else if (d_cmp < CMP_BITS'(near_reg))
        begin
            left_next   = '0;
            right_next  = '0;
            active_next = 1'b1;
            phase_next  = 1'b0;
            count_next  = '0;
        end
        else if (d_cmp > CMP_BITS'(far_reg))
        begin
            left_next  = SPEED_BITS'(FULL_SPEED);
            right_next = SPEED_BITS'(FULL_SPEED);
        end
        else
        begin
            left_next  = {1'b0, ramp_spd};
            right_next = {1'b0, ramp_spd};
            if (ramp_spd < min_spd_reg)
            begin
                active_next = 1'b1;
                phase_next  = 1'b0;
                count_next  = '0;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (sample_ch.ready)
            s1_valid_reg <= sample_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_sample_reg <= sample_ch.distance_sample;
    end

    // controller state advances as each request moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            seen_first_reg <= 1'b0;
            active_reg     <= 1'b0;
            phase_reg      <= 1'b0;
            count_reg      <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end
        else if (s1_adv)
        begin
            prev_reg       <= s1_sample_reg;
            seen_first_reg <= 1'b1;
            active_reg     <= active_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            held_left_reg  <= left_next;
            held_right_reg <= right_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (speed_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_left_reg   <= left_next;
            out_right_reg  <= right_next;
            out_search_reg <= active_next;
        end
    end

    // empty result register never blocks a new request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample_ch.ready)
        else $error("sample channel stalled with empty result register");

    // a request leaving the input register lands in the result register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced request did not reach result register");

    // previous sample tracks the request just processed
    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (prev_reg == $past(s1_sample_reg)))
        else $error("previous sample not updated");

    // first-sample flag never drops outside reset
    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seen_first_reg |=> seen_first_reg)
        else $error("first-sample flag cleared");

endmodule
